// ----- rtl/m4ct_pkg.sv -----
// Shared types and constants for the 4x4 matrix column transform unit.
package m4ct_pkg;

	localparam int DATA_W      = 32;
	localparam int NUM_ROWS    = 4;
	localparam int NUM_ELEMS   = NUM_ROWS * NUM_ROWS;
	localparam int INDEX_W     = $clog2(NUM_ELEMS);
	localparam int PROD_W      = 2 * DATA_W;
	localparam int PAIR_W      = PROD_W + 1;
	localparam int ACC_W       = PROD_W + 2;
	localparam int FRAC_BITS   = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_XFORM = 1'b1;

	typedef struct packed {
		logic                      opcode;
		logic [INDEX_W-1:0]        elem_index;
		logic signed [DATA_W-1:0]  elem_value;
		logic signed [DATA_W-1:0]  col_in_0;
		logic signed [DATA_W-1:0]  col_in_1;
		logic signed [DATA_W-1:0]  col_in_2;
		logic signed [DATA_W-1:0]  col_in_3;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  res_0;
		logic signed [DATA_W-1:0]  res_1;
		logic signed [DATA_W-1:0]  res_2;
		logic signed [DATA_W-1:0]  res_3;
		logic                      saturated;
	} out_item_t;

	// A load carries its value in col[0]; a transform carries the right column.
	typedef struct packed {
		logic                              is_xform;
		logic [INDEX_W-1:0]                index;
		logic [NUM_ROWS-1:0][DATA_W-1:0]   col;
	} cmd_t;

endpackage

// ----- rtl/m4ct_front.sv -----
// Front end: accepts input transactions, classifies them and queues the commands.
module m4ct_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  m4ct_pkg::in_item_t in_data,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output m4ct_pkg::cmd_t    cmd
);
	import m4ct_pkg::*;

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	cmd_t            cmd_in;
	cmd_t            entry_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push;
	logic            pop;

	always_comb begin
		cmd_in.is_xform = (in_data.opcode == OP_XFORM);
		cmd_in.index    = in_data.elem_index;
		if (cmd_in.is_xform) begin
			cmd_in.col[0] = in_data.col_in_0;
			cmd_in.col[1] = in_data.col_in_1;
			cmd_in.col[2] = in_data.col_in_2;
			cmd_in.col[3] = in_data.col_in_3;
		end else begin
			cmd_in.col    = '0;
			cmd_in.col[0] = in_data.elem_value;
		end
	end

	assign in_ready  = (count_q != CntW'(QUEUE_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/m4ct_back.sv -----
// Back end: holds the left matrix and runs the multiply, sum and saturate pipeline.
module m4ct_back #(
	parameter int FracBits = m4ct_pkg::FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  m4ct_pkg::cmd_t     cmd,
	output logic               out_valid,
	input  logic               out_ready,
	output m4ct_pkg::out_item_t out_data
);
	import m4ct_pkg::*;

	logic signed [DATA_W-1:0] matrix_q [NUM_ELEMS];
	logic signed [PROD_W-1:0] prod_s1  [NUM_ROWS][NUM_ROWS];
	logic signed [PAIR_W-1:0] pair_s2  [NUM_ROWS][2];
	logic signed [DATA_W-1:0] res_s3   [NUM_ROWS];
	logic signed [DATA_W-1:0] res_next [NUM_ROWS];
	logic                     sat_s3;
	logic                     sat_next;
	logic                     v_s1;
	logic                     v_s2;
	logic                     v_s3;
	logic                     adv;
	logic                     pop;

	assign adv       = !v_s3 || out_ready;
	assign cmd_ready = adv;
	assign pop       = cmd_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < NUM_ELEMS; e++) begin
				matrix_q[e] <= '0;
			end
		end else if (pop && !cmd.is_xform) begin
			matrix_q[cmd.index] <= $signed(cmd.col[0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop && cmd.is_xform;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		logic signed [ACC_W-1:0] total;
		logic signed [ACC_W-1:0] shifted;
		sat_next = 1'b0;
		for (int i = 0; i < NUM_ROWS; i++) begin
			total = {pair_s2[i][0][PAIR_W-1], pair_s2[i][0]}
				+ {pair_s2[i][1][PAIR_W-1], pair_s2[i][1]};
			shifted = total >>> FracBits;
			if (shifted[ACC_W-1:DATA_W-1] == {(ACC_W-DATA_W+1){shifted[DATA_W-1]}}) begin
				res_next[i] = shifted[DATA_W-1:0];
			end else begin
				sat_next    = 1'b1;
				res_next[i] = shifted[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
					: {1'b0, {(DATA_W-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NUM_ROWS; i++) begin
				for (int k = 0; k < NUM_ROWS; k++) begin
					prod_s1[i][k] <= PROD_W'(matrix_q[NUM_ROWS*k+i])
						* PROD_W'($signed(cmd.col[k]));
				end
				pair_s2[i][0] <= {prod_s1[i][0][PROD_W-1], prod_s1[i][0]}
					+ {prod_s1[i][1][PROD_W-1], prod_s1[i][1]};
				pair_s2[i][1] <= {prod_s1[i][2][PROD_W-1], prod_s1[i][2]}
					+ {prod_s1[i][3][PROD_W-1], prod_s1[i][3]};
				res_s3[i] <= res_next[i];
			end
			sat_s3 <= sat_next;
		end
	end

	assign out_valid          = v_s3;
	assign out_data.res_0     = res_s3[0];
	assign out_data.res_1     = res_s3[1];
	assign out_data.res_2     = res_s3[2];
	assign out_data.res_3     = res_s3[3];
	assign out_data.saturated = sat_s3;

endmodule

// ----- rtl/matrix_4x4_column_transform_unit.sv -----
// Top level of the 4x4 matrix column transform unit.
//
// Input channel (in_valid, in_ready, in_data): each transaction either loads one
// element of the left matrix (column-major index, signed Q16.16 value) or carries
// one column of a right matrix to be transformed. Loads produce no output.
// Output channel (out_valid, out_ready, out_data): one transaction per transform,
// holding the four product elements and a flag that is set if any was clamped.
// Every product sum is shifted right arithmetically by FracBits and saturated
// to 32 bits. Loads and transforms take effect in arrival order.
// A transform is registered in the command queue and then in the multiply, add and
// saturate stages before its out_valid rises. One transaction is accepted per cycle
// while in_ready is high; the two-entry command queue feeds a three-stage pipeline.
// When the receiver stalls, the pipeline holds and the queue fills, after which
// in_ready drops. Reset clears the left matrix to zero and empties the queue
// and the pipeline.
module matrix_4x4_column_transform_unit #(
	parameter int FracBits = m4ct_pkg::FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  m4ct_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output m4ct_pkg::out_item_t out_data
);
	import m4ct_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;

	m4ct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	m4ct_back #(
		.FracBits (FracBits)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- tb/matrix_4x4_column_transform_unit_tb.sv -----
// Self-checking testbench for the 4x4 matrix column transform unit.
`timescale 1ns / 100ps

module matrix_4x4_column_transform_unit_tb;

	import m4ct_pkg::*;

	localparam int LONG_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES     = 16;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	logic signed [DATA_W-1:0] left_elems [NUM_ELEMS];
	out_item_t                product_queue [$];
	int                       mismatch_count;
	int                       tx_idle_pct;
	int                       rx_stall_pct;
	bit                       hold_req;
	dir_row_t                 dir_rows [$];

	matrix_4x4_column_transform_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("matrix_4x4_column_transform_unit_tb NOT OK");
		$finish;
	end

	function automatic out_item_t column_product(in_item_t it);
		logic signed [DATA_W-1:0] cols [NUM_ROWS];
		logic signed [DATA_W-1:0] res [NUM_ROWS];
		logic signed [ACC_W-1:0]  acc;
		logic signed [ACC_W-1:0]  lhs;
		logic signed [ACC_W-1:0]  rhs;
		out_item_t                o;
		bit                       sat;
		cols[0] = it.col_in_0;
		cols[1] = it.col_in_1;
		cols[2] = it.col_in_2;
		cols[3] = it.col_in_3;
		sat = 1'b0;
		for (int i = 0; i < NUM_ROWS; i++) begin
			acc = '0;
			for (int k = 0; k < NUM_ROWS; k++) begin
				lhs = left_elems[4*k+i];
				rhs = cols[k];
				acc = acc + lhs * rhs;
			end
			acc = acc >>> FRAC_BITS;
			if (acc[ACC_W-1:DATA_W-1] == '0 || acc[ACC_W-1:DATA_W-1] == '1) begin
				res[i] = acc[DATA_W-1:0];
			end else begin
				sat = 1'b1;
				res[i] = acc[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end
		end
		o.res_0 = res[0];
		o.res_1 = res[1];
		o.res_2 = res[2];
		o.res_3 = res[3];
		o.saturated = sat;
		return o;
	endfunction

	function automatic out_item_t make_result(logic [31:0] r0, logic [31:0] r1,
			logic [31:0] r2, logic [31:0] r3, logic sat);
		out_item_t o;
		o.res_0 = r0;
		o.res_1 = r1;
		o.res_2 = r2;
		o.res_3 = r3;
		o.saturated = sat;
		return o;
	endfunction

	function automatic dir_row_t load_row(logic [INDEX_W-1:0] idx, logic [31:0] val);
		dir_row_t r;
		r.item.opcode = OP_LOAD;
		r.item.elem_index = idx;
		r.item.elem_value = val;
		r.item.col_in_0 = 32'hDEAD_BEEF;
		r.item.col_in_1 = 32'h5A5A_A5A5;
		r.item.col_in_2 = 32'hFFFF_FFFF;
		r.item.col_in_3 = 32'h8000_0001;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic dir_row_t xform_row(logic [31:0] c0, logic [31:0] c1,
			logic [31:0] c2, logic [31:0] c3, bit typed, out_item_t want);
		dir_row_t r;
		r.item.opcode = OP_XFORM;
		r.item.elem_index = 4'hF;
		r.item.elem_value = 32'h7FFF_FFFF;
		r.item.col_in_0 = c0;
		r.item.col_in_1 = c1;
		r.item.col_in_2 = c2;
		r.item.col_in_3 = c3;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic logic [31:0] rand_fixed();
		logic [31:0] v;
		v = $urandom();
		case ($urandom_range(3))
			0: begin
				return v;
			end
			1: begin
				return {{12{v[19]}}, v[19:0]};
			end
			2: begin
				return {{8{v[23]}}, v[23:0]};
			end
			default: begin
				case ($urandom_range(6))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					3: return 32'h0001_0000;
					4: return 32'hFFFF_0000;
					5: return 32'hFFFF_FFFF;
					default: return 32'h0000_0001;
				endcase
			end
		endcase
	endfunction

	function automatic in_item_t rand_item(logic op);
		in_item_t it;
		it.opcode = op;
		it.elem_index = INDEX_W'($urandom());
		it.elem_value = rand_fixed();
		it.col_in_0 = rand_fixed();
		it.col_in_1 = rand_fixed();
		it.col_in_2 = rand_fixed();
		it.col_in_3 = rand_fixed();
		return it;
	endfunction

	task automatic send_item(in_item_t it, bit typed, out_item_t want);
		if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (it.opcode == OP_LOAD)
			left_elems[it.elem_index] = it.elem_value;
		else
			product_queue.push_back(typed ? want : column_product(it));
	endtask

	task automatic run_random(int n_items, int tx_pct, int rx_pct);
		int sent;
		int n_loads;
		sent = 0;
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		while (sent < n_items) begin
			if ($urandom_range(9) < 8) begin
				n_loads = $urandom_range(1, NUM_ELEMS);
				repeat (n_loads)
					send_item(rand_item(OP_LOAD), 1'b0, '0);
				repeat (NUM_ROWS)
					send_item(rand_item(OP_XFORM), 1'b0, '0);
				sent += n_loads + NUM_ROWS;
			end else begin
				send_item(rand_item(1'($urandom_range(1))), 1'b0, '0);
				sent++;
			end
		end
	endtask

	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES)
					@(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (product_queue.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected transaction: %h %h %h %h sat %b", out_data.res_0,
						out_data.res_1, out_data.res_2, out_data.res_3, out_data.saturated);
			end else begin
				want = product_queue.pop_front();
				if (out_data.res_0 !== want.res_0 || out_data.res_1 !== want.res_1 ||
						out_data.res_2 !== want.res_2 || out_data.res_3 !== want.res_3 ||
						out_data.saturated !== want.saturated) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Mismatch: expected %h %h %h %h sat %b, got %h %h %h %h sat %b",
							want.res_0, want.res_1, want.res_2, want.res_3, want.saturated,
							out_data.res_0, out_data.res_1, out_data.res_2, out_data.res_3,
							out_data.saturated);
				end
			end
		end
	end

	initial begin
		mismatch_count = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_req = 1'b0;
		for (int i = 0; i < NUM_ELEMS; i++)
			left_elems[i] = '0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;

		dir_rows.push_back(xform_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
			32'hFFFF_FFFF, 1'b1, make_result('0, '0, '0, '0, 1'b0)));
		dir_rows.push_back(load_row(4'd0, 32'h0001_0000));
		dir_rows.push_back(load_row(4'd5, 32'h0001_0000));
		dir_rows.push_back(load_row(4'd10, 32'h0001_0000));
		dir_rows.push_back(load_row(4'd15, 32'h0001_0000));
		dir_rows.push_back(xform_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
			32'hFFFF_FFFF, 1'b1, make_result(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
			32'hFFFF_FFFF, 1'b0)));
		dir_rows.push_back(load_row(4'd0, 32'h7FFF_FFFF));
		dir_rows.push_back(xform_row(32'h7FFF_FFFF, '0, '0, '0, 1'b1,
			make_result(32'h7FFF_FFFF, '0, '0, '0, 1'b1)));
		dir_rows.push_back(xform_row(32'h8000_0000, '0, '0, '0, 1'b1,
			make_result(32'h8000_0000, '0, '0, '0, 1'b1)));
		dir_rows.push_back(load_row(4'd0, 32'h8000_0000));
		dir_rows.push_back(xform_row(32'h8000_0000, '0, '0, '0, 1'b1,
			make_result(32'h7FFF_FFFF, '0, '0, '0, 1'b1)));
		dir_rows.push_back(xform_row(32'h7FFF_FFFF, '0, '0, '0, 1'b1,
			make_result(32'h8000_0000, '0, '0, '0, 1'b1)));
		dir_rows.push_back(load_row(4'd0, 32'hFFFF_FFFF));
		dir_rows.push_back(xform_row(32'h0000_0001, '0, '0, '0, 1'b1,
			make_result(32'hFFFF_FFFF, '0, '0, '0, 1'b0)));
		dir_rows.push_back(load_row(4'd0, 32'h8000_0000));
		dir_rows.push_back(load_row(4'd4, 32'h8000_0000));
		dir_rows.push_back(load_row(4'd8, 32'h8000_0000));
		dir_rows.push_back(load_row(4'd12, 32'h8000_0000));
		dir_rows.push_back(xform_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 1'b1, make_result(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 1'b1)));
		dir_rows.push_back(xform_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 1'b0, '0));
		dir_rows.push_back(load_row(4'd15, 32'h7FFF_FFFF));
		dir_rows.push_back(load_row(4'd3, 32'h1234_5678));
		dir_rows.push_back(xform_row(32'h0001_8000, 32'hFFFE_8000, 32'h0000_0001,
			32'h7FFF_FFFF, 1'b0, '0));
		dir_rows.push_back(xform_row('0, '0, '0, '0, 1'b1,
			make_result('0, '0, '0, '0, 1'b0)));

		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

		hold_req = 1'b1;
		run_random(460, 0, 0);
		run_random(460, 46, 0);
		run_random(460, 0, 46);
		run_random(470, 35, 35);
		in_valid <= 1'b0;

		while (product_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (mismatch_count == 0)
			$display("matrix_4x4_column_transform_unit_tb OK");
		else
			$display("matrix_4x4_column_transform_unit_tb NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/m4ct_pkg.sv
rtl/m4ct_front.sv
rtl/m4ct_back.sv
rtl/matrix_4x4_column_transform_unit.sv
tb/matrix_4x4_column_transform_unit_tb.sv
